// ===== sv/cbm_pkg.sv =====
// shared types and constants of the copier board mapper
package cbm_pkg;

	// input item kinds
	typedef enum logic [1:0] {
		KIND_LOW  = 2'd0,
		KIND_HIGH = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	// result update codes
	typedef enum logic [2:0] {
		UPD_NONE   = 3'd0,
		UPD_MIRROR = 3'd1,
		UPD_PRG16  = 3'd2,
		UPD_PRG8   = 3'd3,
		UPD_CHR8   = 3'd4,
		UPD_CHR1   = 3'd5
	} update_t;

	// name-table mirroring codes
	typedef enum logic [1:0] {
		MIR_LOW  = 2'd0,
		MIR_HIGH = 2'd1,
		MIR_VERT = 2'd2,
		MIR_HORZ = 2'd3
	} mirror_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_BOARD_VARIANT   = 2'd0,
		REG_PATTERN_IS_ROM  = 2'd1,
		REG_CYCLES_PER_TICK = 2'd2
	} cfg_reg_t;

	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned CfgDataW  = 10;
	localparam int unsigned TickW     = 10;
	localparam int unsigned CountW    = 16;

	// configuration reset values
	localparam logic             RstBoardVariant = 1'b0;
	localparam logic             RstPatternIsRom = 1'b1;
	localparam logic [TickW-1:0] RstCyclesPerTick = 10'd114;

	// low-area register offsets
	localparam logic [12:0] OFS_MIR_SINGLE = 13'h1fe;
	localparam logic [12:0] OFS_MIR_VH     = 13'h1ff;
	localparam logic [12:0] OFS_IRQ_EN     = 13'h401;
	localparam logic [12:0] OFS_IRQ_LO     = 13'h402;
	localparam logic [12:0] OFS_IRQ_HI     = 13'h403;
	localparam logic [12:0] OFS_PRG8       = 13'h404;
	localparam logic [12:0] OFS_CHR1       = 13'h410;

	localparam logic [CountW-1:0] CountMax = 16'hffff;

	// one result item without its last flag
	typedef struct packed {
		logic       irq_fire;
		update_t    update;
		logic [2:0] slot;
		logic [7:0] bank;
		mirror_t    mirroring;
	} res_t;

endpackage

// ===== sv/cbm_if.sv =====
// handshake channels for input items and result items
interface cbm_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [12:0] offset;
	logic [7:0]  data;

	modport source (output valid, output kind, output offset, output data, input ready);
	modport sink (input valid, input kind, input offset, input data, output ready);
endinterface

interface cbm_result_if;
	logic       valid;
	logic       ready;
	logic       irq_fire;
	logic [2:0] update;
	logic [2:0] slot;
	logic [7:0] bank;
	logic [1:0] mirroring;
	logic       last;

	modport source (output valid, output irq_fire, output update, output slot,
		output bank, output mirroring, output last, input ready);
	modport sink (input valid, input irq_fire, input update, input slot,
		input bank, input mirroring, input last, output ready);
endinterface

// ===== sv/copier_board_mapper_irq.sv =====
// Copier board mapper bank and scanline IRQ logic, variants 6 and 17.
// Path: an accepted item is held in the input register, and its first result is
// loaded into the result register when the item retires from it.
// Throughput: one item per cycle while the result register is free; a high-area
// write with two results holds it for two transactions, setting the rate for such writes.
// Reset (arst_n low) clears the IRQ count, IRQ enable, mode latch, all valid flags
// and returns configuration to variant 6, pattern ROM, 114 per tick.
module copier_board_mapper_irq
	import cbm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	cbm_item_if.sink             item,
	cbm_result_if.source         result,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	// configuration
	logic             board_variant_q;
	logic             pattern_is_rom_q;
	logic [TickW-1:0] cycles_per_tick_q;

	// mapper state
	logic [CountW-1:0] irq_counter_q;
	logic              irq_enabled_q;
	logic              mode_latch_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [12:0] offset_s1;
	logic [7:0]  data_s1;

	// result register
	logic out_valid_q;
	logic out_two_q;
	logic out_idx_q;
	res_t out_r0_q;
	res_t out_r1_q;

	// processing logic
	logic              has0;
	logic              has1;
	res_t              r0;
	res_t              r1;
	logic [CountW-1:0] irq_counter_d;
	logic              irq_enabled_d;
	logic              mode_latch_d;
	logic              fire;
	logic [CountW-1:0] headroom;
	logic [CountW-1:0] tick_amt;

	logic advance;
	logic out_take;
	logic out_last;
	logic out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_variant_q   <= RstBoardVariant;
			pattern_is_rom_q  <= RstPatternIsRom;
			cycles_per_tick_q <= RstCyclesPerTick;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BOARD_VARIANT:   board_variant_q   <= cfg_data[0];
				REG_PATTERN_IS_ROM:  pattern_is_rom_q  <= cfg_data[0];
				REG_CYCLES_PER_TICK: cycles_per_tick_q <= cfg_data[TickW-1:0];
				default: ;
			endcase
		end
	end

	// tick arithmetic
	assign tick_amt = {{(CountW-TickW){1'b0}}, cycles_per_tick_q};
	assign headroom = CountMax - irq_counter_q;
	assign fire     = irq_enabled_q && (headroom < tick_amt);

	// decode the staged item into results and next state
	always_comb begin
		has0          = 1'b0;
		has1          = 1'b0;
		r0            = '0;
		r1            = '0;
		irq_counter_d = irq_counter_q;
		irq_enabled_d = irq_enabled_q;
		mode_latch_d  = mode_latch_q;
		unique case (kind_s1)
			KIND_LOW: begin
				priority if (offset_s1 == OFS_MIR_SINGLE) begin
					if (!board_variant_q) mode_latch_d = data_s1[7];
					has0         = 1'b1;
					r0.update    = UPD_MIRROR;
					r0.mirroring = data_s1[4] ? MIR_HIGH : MIR_LOW;
				end else if (offset_s1 == OFS_MIR_VH) begin
					has0         = 1'b1;
					r0.update    = UPD_MIRROR;
					r0.mirroring = data_s1[4] ? MIR_HORZ : MIR_VERT;
				end else if (offset_s1 == OFS_IRQ_EN) begin
					irq_enabled_d = data_s1[0];
				end else if (offset_s1 == OFS_IRQ_LO) begin
					irq_counter_d = {irq_counter_q[15:8], data_s1};
				end else if (offset_s1 == OFS_IRQ_HI) begin
					irq_enabled_d = 1'b1;
					irq_counter_d = {data_s1, irq_counter_q[7:0]};
				end else if (board_variant_q && offset_s1[12:2] == OFS_PRG8[12:2]) begin
					has0      = 1'b1;
					r0.update = UPD_PRG8;
					r0.slot   = {1'b0, offset_s1[1:0]};
					r0.bank   = data_s1;
				end else if (board_variant_q && offset_s1[12:3] == OFS_CHR1[12:3]) begin
					has0      = 1'b1;
					r0.update = UPD_CHR1;
					r0.slot   = offset_s1[2:0];
					r0.bank   = data_s1;
				end else begin
				end
			end
			KIND_HIGH: begin
				if (!board_variant_q) begin
					if (!mode_latch_q) begin
						has0      = 1'b1;
						r0.update = UPD_PRG16;
						r0.bank   = {2'b00, data_s1[7:2]};
						has1      = pattern_is_rom_q;
						r1.update = UPD_CHR8;
						r1.bank   = {6'd0, data_s1[1:0]};
					end else if (pattern_is_rom_q) begin
						has0      = 1'b1;
						r0.update = UPD_CHR8;
						r0.bank   = data_s1;
					end
				end
			end
			KIND_TICK: begin
				if (irq_enabled_q) begin
					if (fire) begin
						irq_enabled_d = 1'b0;
						irq_counter_d = CountMax - tick_amt;
						has0          = 1'b1;
						r0.irq_fire   = 1'b1;
					end else begin
						irq_counter_d = irq_counter_q - tick_amt;
					end
				end
			end
			default: ;
		endcase
	end

	// flow control between input stage and result register
	assign out_take = out_valid_q && result.ready;
	assign out_last = !out_two_q || out_idx_q;
	assign out_free = !out_valid_q || (out_take && out_last);
	assign advance  = valid_s1 && (!has0 || out_free);
	assign item.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1   <= item.kind;
			offset_s1 <= item.offset;
			data_s1   <= item.data;
		end
	end

	// mapper state update when the staged item retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_counter_q <= '0;
			irq_enabled_q <= 1'b0;
			mode_latch_q  <= 1'b0;
		end else if (advance) begin
			irq_counter_q <= irq_counter_d;
			irq_enabled_q <= irq_enabled_d;
			mode_latch_q  <= mode_latch_d;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_two_q   <= 1'b0;
			out_idx_q   <= 1'b0;
		end else if (advance && has0) begin
			out_valid_q <= 1'b1;
			out_two_q   <= has1;
			out_idx_q   <= 1'b0;
		end else if (out_take) begin
			if (out_last) out_valid_q <= 1'b0;
			else out_idx_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has0) begin
			out_r0_q <= r0;
			out_r1_q <= r1;
		end
	end

	// result port
	res_t out_cur;
	assign out_cur          = out_idx_q ? out_r1_q : out_r0_q;
	assign result.valid     = out_valid_q;
	assign result.irq_fire  = out_cur.irq_fire;
	assign result.update    = out_cur.update;
	assign result.slot      = out_cur.slot;
	assign result.bank      = out_cur.bank;
	assign result.mirroring = out_cur.mirroring;
	assign result.last      = out_last;

`ifndef SYNTHESIS
	// second result selected only for a two-result item
	assert property (@(posedge clk) disable iff (!arst_n) out_idx_q |-> out_two_q)
		else $error("second result selected without a pair");

	// an interrupt result carries no update and ends its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_cur.irq_fire) |-> (out_cur.update == UPD_NONE && out_last))
		else $error("interrupt result malformed");

	// a firing tick disables the IRQ
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kind_s1 == KIND_TICK && fire) |=> !irq_enabled_q)
		else $error("IRQ still enabled after firing");

	// a result pair is always a program bank followed by a pattern bank
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_two_q) |->
		(out_r0_q.update == UPD_PRG16 && out_r1_q.update == UPD_CHR8))
		else $error("unexpected result pair");

	// results and the item that caused them do not overlap in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has0) |-> out_free)
		else $error("result register overwritten");
`endif

endmodule
